[src/ris_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types of the range image segmentation block.
// Used by ris_join and range_image_segmentation; depends on nothing.
package ris_pkg;

    localparam int ROWS        = 16;
    localparam int MAX_COLS    = 2048;
    localparam int BIG_SEGMENT = 30;

    localparam int ROW_W     = 4;
    localparam int COL_W     = 11;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int CNT_W     = ADDR_W + 1;
    localparam int COLS_W    = 12;
    localparam int RANGE_W   = 24;
    localparam int LABEL_W   = 17;
    localparam int SEG_W     = 16;
    localparam int TRIG_W    = 17;
    localparam int TAN_W     = 20;
    localparam int MINP_W    = 16;
    localparam int MINL_W    = 5;
    localparam int LINES_W   = $clog2(ROWS + 1);
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;

    localparam logic [LABEL_W-1:0] LBL_NONE     = 17'h00000;
    localparam logic [LABEL_W-1:0] LBL_BLOCKED  = 17'h10001;
    localparam logic [LABEL_W-1:0] LBL_REJECTED = 17'h10002;
    localparam logic [LABEL_W-1:0] LBL_MAX_SEG  = 17'h08000;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_UNLABELED = 2'd0,
        KIND_BLOCKED   = 2'd1,
        KIND_KEPT      = 2'd2,
        KIND_REJECTED  = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS      = 3'd0,
        CFG_SIN_H     = 3'd1,
        CFG_COS_H     = 3'd2,
        CFG_SIN_V     = 3'd3,
        CFG_COS_V     = 3'd4,
        CFG_TAN       = 3'd5,
        CFG_MIN_PTS   = 3'd6,
        CFG_MIN_LINES = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        NB_LEFT  = 2'd0,
        NB_UP    = 2'd1,
        NB_DOWN  = 2'd2,
        NB_RIGHT = 2'd3
    } nb_dir_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_LABEL,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SEED,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_PRANGE,
        ST_NB_SEL,
        ST_NB_CHK,
        ST_NB_JOIN,
        ST_FIN_CNT,
        ST_FIN_DEC,
        ST_REJ_RD,
        ST_REJ_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [TRIG_W-1:0] sin_h;
        logic [TRIG_W-1:0] cos_h;
        logic [TRIG_W-1:0] sin_v;
        logic [TRIG_W-1:0] cos_v;
        logic [TAN_W-1:0]  tan;
    } trig_cfg_t;

    typedef struct packed {
        logic               valid;
        logic [RANGE_W-1:0] ra;
        logic [RANGE_W-1:0] rb;
        logic               horiz;
    } join_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } join_rsp_t;

endpackage

[src/ris_ram.sv]
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; no package dependency.
module ris_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/ris_join.sv]
`timescale 1ns / 1ps
// Pipelined angle test between two neighboring ranges.
// Depends on ris_pkg for widths and the request and response structs.
module ris_join (
    input  logic               aclk,
    input  logic               aresetn,
    input  ris_pkg::trig_cfg_t trig,
    input  ris_pkg::join_req_t req,
    output ris_pkg::join_rsp_t rsp
);

    logic [4:0] vld_reg;

    logic [ris_pkg::RANGE_W-1:0] d1_reg, d2_reg, d1b_reg;
    logic [ris_pkg::TRIG_W-1:0]  s_reg, c_reg;
    logic [40:0]                 ms_reg, mc_reg, ms2_reg, ms3_reg;
    logic signed [42:0]          den_reg;
    logic [41:0]                 plo_reg;
    logic signed [41:0]          phi_reg;
    logic                        hit_reg;

    logic signed [42:0] den_next;
    logic signed [63:0] lhs, rhs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], req.valid};
        end
    end

    assign den_next = $signed({3'b000, d1b_reg, 16'h0000}) - $signed({2'b00, mc_reg});
    assign lhs      = $signed({7'd0, ms3_reg, 16'h0000});
    assign rhs      = $signed({phi_reg, 22'd0}) + $signed({22'd0, plo_reg});

    always_ff @(posedge aclk) begin
        // Order the pair so that d1 is the larger range.
        if (req.ra > req.rb) begin
            d1_reg <= req.ra;
            d2_reg <= req.rb;
        end else begin
            d1_reg <= req.rb;
            d2_reg <= req.ra;
        end
        s_reg   <= req.horiz ? trig.sin_h : trig.sin_v;
        c_reg   <= req.horiz ? trig.cos_h : trig.cos_v;

        ms_reg  <= d2_reg * s_reg;
        mc_reg  <= d2_reg * c_reg;
        d1b_reg <= d1_reg;

        den_reg <= den_next;
        ms2_reg <= ms_reg;

        // The threshold product is split at bit 22 of the difference.
        plo_reg <= trig.tan * den_reg[21:0];
        phi_reg <= $signed({1'b0, trig.tan}) * $signed(den_reg[42:22]);
        ms3_reg <= ms2_reg;

        hit_reg <= lhs > rhs;
    end

    assign rsp.done = vld_reg[4];
    assign rsp.hit  = hit_reg;

endmodule

[src/range_image_segmentation.sv]
`timescale 1ns / 1ps
// Top level: configuration, image stores, flood sequencer and result register.
// Depends on ris_pkg, ris_ram and ris_join.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  s_       | s_valid / s_ready    | operation, row, col, range, blocked
//  m_       | m_valid / m_ready    | label_kind, segment_id, segment_count
//  cfg_     | cfg_wr_en            | cfg_addr, cfg_wdata
//
// A load is written straight from idle and a read answers from the label read state;
// a start scans each pixel, seeds each unlabeled one, takes pixels off the visit list,
// runs the five-stage angle test on each unlabeled neighbor and relabels rejected pixels.
// Reset is synchronous, clears control state and sets configuration defaults; stores need no clearing.
// The input is taken only while the sequencer is idle; a finished word waits in
// the output register and does not stop loads.
module range_image_segmentation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [3:0]  s_row,
    input  logic [10:0] s_col,
    input  logic [23:0] s_range,
    input  logic        s_blocked,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_label_kind,
    output logic [15:0] m_segment_id,
    output logic [15:0] m_segment_count,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [19:0] cfg_wdata
);

    // Configuration registers.
    logic [ris_pkg::COLS_W-1:0] cols_in_use_reg;
    logic [ris_pkg::MINP_W-1:0] min_points_reg;
    logic [ris_pkg::MINL_W-1:0] min_lines_reg;
    ris_pkg::trig_cfg_t         trig_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_in_use_reg <= 12'd1800;
            trig_reg.sin_h  <= 17'd229;
            trig_reg.cos_h  <= 17'd65536;
            trig_reg.sin_v  <= 17'd2285;
            trig_reg.cos_v  <= 17'd65496;
            trig_reg.tan    <= 20'd113512;
            min_points_reg  <= 16'd5;
            min_lines_reg   <= 5'd3;
        end else if (cfg_wr_en) begin
            unique case (ris_pkg::cfg_idx_t'(cfg_addr))
                ris_pkg::CFG_COLS:      cols_in_use_reg <= cfg_wdata[11:0];
                ris_pkg::CFG_SIN_H:     trig_reg.sin_h  <= cfg_wdata[16:0];
                ris_pkg::CFG_COS_H:     trig_reg.cos_h  <= cfg_wdata[16:0];
                ris_pkg::CFG_SIN_V:     trig_reg.sin_v  <= cfg_wdata[16:0];
                ris_pkg::CFG_COS_V:     trig_reg.cos_v  <= cfg_wdata[16:0];
                ris_pkg::CFG_TAN:       trig_reg.tan    <= cfg_wdata[19:0];
                ris_pkg::CFG_MIN_PTS:   min_points_reg  <= cfg_wdata[15:0];
                ris_pkg::CFG_MIN_LINES: min_lines_reg   <= cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    // Memories.
    logic                        lbl_we, lbl_re, rng_we, rng_re, vis_we, vis_re;
    logic [ris_pkg::ADDR_W-1:0]  lbl_waddr, lbl_raddr, rng_waddr, rng_raddr;
    logic [ris_pkg::ADDR_W-1:0]  vis_waddr, vis_raddr, vis_wdata, vis_rdata;
    logic [ris_pkg::LABEL_W-1:0] lbl_wdata, lbl_rdata;
    logic [ris_pkg::RANGE_W-1:0] rng_wdata, rng_rdata;

    ris_ram #(.DATA_W(ris_pkg::LABEL_W), .ADDR_W(ris_pkg::ADDR_W)) u_label_ram (
        .aclk(aclk), .we(lbl_we), .waddr(lbl_waddr), .wdata(lbl_wdata),
        .re(lbl_re), .raddr(lbl_raddr), .rdata(lbl_rdata)
    );

    ris_ram #(.DATA_W(ris_pkg::RANGE_W), .ADDR_W(ris_pkg::ADDR_W)) u_range_ram (
        .aclk(aclk), .we(rng_we), .waddr(rng_waddr), .wdata(rng_wdata),
        .re(rng_re), .raddr(rng_raddr), .rdata(rng_rdata)
    );

    ris_ram #(.DATA_W(ris_pkg::ADDR_W), .ADDR_W(ris_pkg::ADDR_W)) u_visit_ram (
        .aclk(aclk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .re(vis_re), .raddr(vis_raddr), .rdata(vis_rdata)
    );

    // Angle test.
    ris_pkg::join_req_t join_req;
    ris_pkg::join_rsp_t join_rsp;

    ris_join u_join (
        .aclk(aclk), .aresetn(aresetn), .trig(trig_reg), .req(join_req), .rsp(join_rsp)
    );

    // Sequencer state.
    ris_pkg::state_t             state_reg, state_next;
    logic [ris_pkg::ROW_W-1:0]   scan_r_reg, scan_r_next;
    logic [ris_pkg::COL_W-1:0]   scan_c_reg, scan_c_next;
    logic [ris_pkg::COLS_W-1:0]  cols_reg, cols_next;
    logic [ris_pkg::SEG_W-1:0]   next_seg_reg, next_seg_next;
    logic [ris_pkg::CNT_W-1:0]   head_reg, head_next, tail_reg, tail_next;
    ris_pkg::nb_dir_t            k_reg, k_next;
    logic [ris_pkg::ADDR_W-1:0]  p_reg, p_next, q_reg, q_next;
    logic [ris_pkg::RANGE_W-1:0] rp_reg, rp_next;
    logic [ris_pkg::ROWS-1:0]    touched_reg, touched_next;
    logic [ris_pkg::LINES_W-1:0] lines_reg, lines_next;

    logic                        m_valid_reg;
    logic [1:0]                  m_kind_reg;
    logic [ris_pkg::SEG_W-1:0]   m_id_reg, m_count_reg;
    logic                        out_load, out_free;
    ris_pkg::kind_t              out_kind;
    logic [ris_pkg::SEG_W-1:0]   out_id, out_count;

    logic [ris_pkg::ADDR_W-1:0]  s_addr;
    logic [ris_pkg::ROW_W-1:0]   pr, nr;
    logic [ris_pkg::COL_W-1:0]   pc, nc, cols_last;
    logic                        nb_ok, do_adv, keep;

    assign s_addr    = {s_row, s_col};
    assign pr        = p_reg[ris_pkg::ADDR_W-1:ris_pkg::COL_W];
    assign pc        = p_reg[ris_pkg::COL_W-1:0];
    assign cols_last = ris_pkg::COL_W'(cols_reg - 12'd1);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ris_pkg::ST_IDLE);

    assign keep = (tail_reg >= ris_pkg::CNT_W'(ris_pkg::BIG_SEGMENT)) ||
                  ((tail_reg >= {1'b0, min_points_reg}) &&
                   (lines_reg >= min_lines_reg));

    // Neighbor address with column wrap; rows do not wrap.
    always_comb begin
        nr    = pr;
        nc    = pc;
        nb_ok = 1'b1;
        unique case (k_reg)
            ris_pkg::NB_LEFT: begin
                nc = (pc == '0) ? cols_last : pc - 11'd1;
            end
            ris_pkg::NB_UP: begin
                nb_ok = (pr != '0);
                nr    = pr - 4'd1;
            end
            ris_pkg::NB_DOWN: begin
                nb_ok = (pr != ris_pkg::ROW_W'(ris_pkg::ROWS - 1));
                nr    = pr + 4'd1;
            end
            ris_pkg::NB_RIGHT: begin
                nc = ({1'b0, pc} + 12'd1 >= cols_reg) ? '0 : pc + 11'd1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        scan_r_next   = scan_r_reg;
        scan_c_next   = scan_c_reg;
        cols_next     = cols_reg;
        next_seg_next = next_seg_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        k_next        = k_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        rp_next       = rp_reg;
        touched_next  = touched_reg;
        lines_next    = lines_reg;
        do_adv        = 1'b0;

        lbl_we    = 1'b0;
        lbl_waddr = s_addr;
        lbl_wdata = s_blocked ? ris_pkg::LBL_BLOCKED : ris_pkg::LBL_NONE;
        lbl_re    = 1'b0;
        lbl_raddr = s_addr;
        rng_we    = 1'b0;
        rng_waddr = s_addr;
        rng_wdata = s_range;
        rng_re    = 1'b0;
        rng_raddr = q_reg;
        vis_we    = 1'b0;
        vis_waddr = tail_reg[ris_pkg::ADDR_W-1:0];
        vis_wdata = q_reg;
        vis_re    = 1'b0;
        vis_raddr = head_reg[ris_pkg::ADDR_W-1:0];

        join_req.valid = 1'b0;
        join_req.ra    = rp_reg;
        join_req.rb    = rng_rdata;
        join_req.horiz = (k_reg == ris_pkg::NB_LEFT) || (k_reg == ris_pkg::NB_RIGHT);

        out_load  = 1'b0;
        out_kind  = ris_pkg::KIND_UNLABELED;
        out_id    = '0;
        out_count = '0;

        unique case (state_reg)
            ris_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (ris_pkg::op_t'(s_operation))
                        ris_pkg::OP_LOAD: begin
                            lbl_we = 1'b1;
                            rng_we = 1'b1;
                        end
                        ris_pkg::OP_START: begin
                            cols_next     = (cols_in_use_reg > ris_pkg::COLS_W'(ris_pkg::MAX_COLS))
                                            ? ris_pkg::COLS_W'(ris_pkg::MAX_COLS)
                                            : cols_in_use_reg;
                            scan_r_next   = '0;
                            scan_c_next   = '0;
                            next_seg_next = 16'd1;
                            state_next    = (cols_in_use_reg == '0) ? ris_pkg::ST_DONE
                                                                    : ris_pkg::ST_SCAN_RD;
                        end
                        ris_pkg::OP_READ: begin
                            lbl_re     = 1'b1;
                            state_next = ris_pkg::ST_RD_LABEL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ris_pkg::ST_RD_LABEL: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (lbl_rdata == ris_pkg::LBL_BLOCKED) begin
                        out_kind = ris_pkg::KIND_BLOCKED;
                    end else if (lbl_rdata == ris_pkg::LBL_REJECTED) begin
                        out_kind = ris_pkg::KIND_REJECTED;
                    end else if (lbl_rdata != ris_pkg::LBL_NONE &&
                                 lbl_rdata <= ris_pkg::LBL_MAX_SEG) begin
                        out_kind = ris_pkg::KIND_KEPT;
                        out_id   = lbl_rdata[ris_pkg::SEG_W-1:0];
                    end
                    state_next = ris_pkg::ST_IDLE;
                end
            end
            ris_pkg::ST_SCAN_RD: begin
                lbl_re     = 1'b1;
                lbl_raddr  = {scan_r_reg, scan_c_reg};
                state_next = ris_pkg::ST_SCAN_CHK;
            end
            ris_pkg::ST_SCAN_CHK: begin
                if (lbl_rdata == ris_pkg::LBL_NONE) begin
                    state_next = ris_pkg::ST_SEED;
                end else begin
                    do_adv = 1'b1;
                end
            end
            ris_pkg::ST_SEED: begin
                lbl_we       = 1'b1;
                lbl_waddr    = {scan_r_reg, scan_c_reg};
                lbl_wdata    = {1'b0, next_seg_reg};
                vis_we       = 1'b1;
                vis_waddr    = '0;
                vis_wdata    = {scan_r_reg, scan_c_reg};
                head_next    = '0;
                tail_next    = 16'd1;
                touched_next = '0;
                state_next   = ris_pkg::ST_POP_RD;
            end
            ris_pkg::ST_POP_RD: begin
                if (head_reg < tail_reg) begin
                    vis_re     = 1'b1;
                    head_next  = head_reg + 16'd1;
                    state_next = ris_pkg::ST_POP_WAIT;
                end else begin
                    state_next = ris_pkg::ST_FIN_CNT;
                end
            end
            ris_pkg::ST_POP_WAIT: begin
                p_next     = vis_rdata;
                rng_re     = 1'b1;
                rng_raddr  = vis_rdata;
                state_next = ris_pkg::ST_PRANGE;
            end
            ris_pkg::ST_PRANGE: begin
                rp_next    = rng_rdata;
                k_next     = ris_pkg::NB_LEFT;
                state_next = ris_pkg::ST_NB_SEL;
            end
            ris_pkg::ST_NB_SEL: begin
                if (nb_ok) begin
                    q_next     = {nr, nc};
                    lbl_re     = 1'b1;
                    lbl_raddr  = {nr, nc};
                    rng_re     = 1'b1;
                    rng_raddr  = {nr, nc};
                    state_next = ris_pkg::ST_NB_CHK;
                end else if (k_reg == ris_pkg::NB_RIGHT) begin
                    state_next = ris_pkg::ST_POP_RD;
                end else begin
                    k_next = ris_pkg::nb_dir_t'(k_reg + 2'd1);
                end
            end
            ris_pkg::ST_NB_CHK: begin
                if (lbl_rdata == ris_pkg::LBL_NONE) begin
                    join_req.valid = 1'b1;
                    state_next     = ris_pkg::ST_NB_JOIN;
                end else if (k_reg == ris_pkg::NB_RIGHT) begin
                    state_next = ris_pkg::ST_POP_RD;
                end else begin
                    k_next     = ris_pkg::nb_dir_t'(k_reg + 2'd1);
                    state_next = ris_pkg::ST_NB_SEL;
                end
            end
            ris_pkg::ST_NB_JOIN: begin
                if (join_rsp.done) begin
                    if (join_rsp.hit) begin
                        lbl_we    = 1'b1;
                        lbl_waddr = q_reg;
                        lbl_wdata = {1'b0, next_seg_reg};
                        vis_we    = 1'b1;
                        tail_next = tail_reg + 16'd1;
                        touched_next[q_reg[ris_pkg::ADDR_W-1:ris_pkg::COL_W]] = 1'b1;
                    end
                    if (k_reg == ris_pkg::NB_RIGHT) begin
                        state_next = ris_pkg::ST_POP_RD;
                    end else begin
                        k_next     = ris_pkg::nb_dir_t'(k_reg + 2'd1);
                        state_next = ris_pkg::ST_NB_SEL;
                    end
                end
            end
            ris_pkg::ST_FIN_CNT: begin
                lines_next = ris_pkg::LINES_W'($countones(touched_reg));
                state_next = ris_pkg::ST_FIN_DEC;
            end
            ris_pkg::ST_FIN_DEC: begin
                if (keep) begin
                    next_seg_next = next_seg_reg + 16'd1;
                    do_adv        = 1'b1;
                end else begin
                    head_next  = '0;
                    state_next = ris_pkg::ST_REJ_RD;
                end
            end
            ris_pkg::ST_REJ_RD: begin
                if (head_reg < tail_reg) begin
                    vis_re     = 1'b1;
                    head_next  = head_reg + 16'd1;
                    state_next = ris_pkg::ST_REJ_WR;
                end else begin
                    do_adv = 1'b1;
                end
            end
            ris_pkg::ST_REJ_WR: begin
                lbl_we     = 1'b1;
                lbl_waddr  = vis_rdata;
                lbl_wdata  = ris_pkg::LBL_REJECTED;
                state_next = ris_pkg::ST_REJ_RD;
            end
            ris_pkg::ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_count  = next_seg_reg - 16'd1;
                    state_next = ris_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ris_pkg::ST_IDLE;
            end
        endcase

        // Step the scan to the next pixel in row-major order.
        if (do_adv) begin
            if ({1'b0, scan_c_reg} == cols_reg - 12'd1) begin
                scan_c_next = '0;
                if (scan_r_reg == ris_pkg::ROW_W'(ris_pkg::ROWS - 1)) begin
                    state_next = ris_pkg::ST_DONE;
                end else begin
                    scan_r_next = scan_r_reg + 4'd1;
                    state_next  = ris_pkg::ST_SCAN_RD;
                end
            end else begin
                scan_c_next = scan_c_reg + 11'd1;
                state_next  = ris_pkg::ST_SCAN_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ris_pkg::ST_IDLE;
            next_seg_reg <= 16'd1;
            head_reg     <= '0;
            tail_reg     <= '0;
            touched_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            next_seg_reg <= next_seg_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            touched_reg  <= touched_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_r_reg <= scan_r_next;
        scan_c_reg <= scan_c_next;
        cols_reg   <= cols_next;
        k_reg      <= k_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        rp_reg     <= rp_next;
        lines_reg  <= lines_next;
        if (out_load) begin
            m_kind_reg  <= out_kind;
            m_id_reg    <= out_id;
            m_count_reg <= out_count;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_label_kind    = m_kind_reg;
    assign m_segment_id    = m_id_reg;
    assign m_segment_count = m_count_reg;

endmodule
